// ===== rtl/escaped_led_command_deframer_defines.svh =====
// Assertion helpers for the LED command deframer.
// All of them sample on clk and are disabled while rst_n is low.
`ifndef ESCAPED_LED_COMMAND_DEFRAMER_DEFINES_SVH
`define ESCAPED_LED_COMMAND_DEFRAMER_DEFINES_SVH

// Same-cycle implication.
`define ELD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ELD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/eld_pkg.sv =====
package eld_pkg;

    localparam int FRAME_BYTES_DEF = 720;
    localparam int COLUMNS_DEF     = 50;
    localparam int ROWS_DEF        = 6;

    localparam int POS_W = 10;

    localparam logic [7:0] BYTE_LED    = 8'h42;
    localparam logic [7:0] BYTE_FRAME  = 8'h23;
    localparam logic [7:0] BYTE_ESCAPE = 8'h65;
    localparam logic [7:0] BYTE_BOOT   = 8'h66;

    localparam logic [7:0] ESC_FRAME  = 8'h01;
    localparam logic [7:0] ESC_LED    = 8'h02;
    localparam logic [7:0] ESC_ESCAPE = 8'h03;
    localparam logic [7:0] ESC_BOOT   = 8'h04;

    typedef enum logic [1:0] {
        KIND_LED   = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_BOOT  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_COLUMN = 3'd1,
        MODE_ROW    = 3'd2,
        MODE_RED    = 3'd3,
        MODE_GREEN  = 3'd4,
        MODE_BLUE   = 3'd5,
        MODE_FRAME  = 3'd6
    } mode_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         column;
        logic [7:0]         row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [POS_W-1:0]   index;
        logic [7:0]         data;
        logic               last;
    } result_t;

    function automatic logic [7:0] unescape(input logic [7:0] v);
        logic [7:0] r;
        begin
            unique case (v)
                ESC_FRAME:  r = BYTE_FRAME;
                ESC_LED:    r = BYTE_LED;
                ESC_ESCAPE: r = BYTE_ESCAPE;
                ESC_BOOT:   r = BYTE_BOOT;
                default:    r = v;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/eld_in_stage.sv =====
module eld_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

// ===== rtl/eld_parser.sv =====
module eld_parser
#(
    parameter int FRAME_BYTES = eld_pkg::FRAME_BYTES_DEF,
    parameter int COLUMNS     = eld_pkg::COLUMNS_DEF,
    parameter int ROWS        = eld_pkg::ROWS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output eld_pkg::result_t result
);

    eld_pkg::mode_t                 mode_reg;
    eld_pkg::mode_t                 mode_next;
    logic                           escape_reg;
    logic                           escape_next;
    logic [3:0][7:0]                held_reg;
    logic [3:0][7:0]                held_next;
    logic [eld_pkg::POS_W-1:0]      pos_reg;
    logic [eld_pkg::POS_W-1:0]      pos_next;

    logic                           is_led;
    logic                           is_frame;
    logic                           is_escape;
    logic                           is_boot;
    logic [7:0]                     data;
    logic                           frame_end;
    logic                           in_range;

    assign is_led     = rx_byte == eld_pkg::BYTE_LED;
    assign is_frame   = rx_byte == eld_pkg::BYTE_FRAME;
    assign is_escape  = rx_byte == eld_pkg::BYTE_ESCAPE;
    assign is_boot    = rx_byte == eld_pkg::BYTE_BOOT;
    assign data       = escape_reg ? eld_pkg::unescape(rx_byte) : rx_byte;

    assign frame_end = ({1'b0, pos_reg} + 11'd1) >= 11'(FRAME_BYTES);
    assign in_range  = (9'(held_reg[0]) < 9'(COLUMNS)) && (9'(held_reg[1]) < 9'(ROWS));

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        escape_next = escape_reg;
        held_next   = held_reg;
        pos_next    = pos_reg;
        if (fire)
        begin
            priority if (is_led)
            begin
                mode_next = eld_pkg::MODE_COLUMN;
            end
            else if (is_frame)
            begin
                mode_next = eld_pkg::MODE_FRAME;
                pos_next  = '0;
            end
            else if (is_escape)
            begin
                escape_next = 1'b1;
            end
            else if (is_boot)
            begin
                mode_next   = eld_pkg::MODE_IDLE;
                escape_next = 1'b0;
                held_next   = '0;
                pos_next    = '0;
            end
            else
            begin
                escape_next = 1'b0;
                unique case (mode_reg)
                    eld_pkg::MODE_COLUMN:
                    begin
                        held_next[0] = data;
                        mode_next    = eld_pkg::MODE_ROW;
                    end
                    eld_pkg::MODE_ROW:
                    begin
                        held_next[1] = data;
                        mode_next    = eld_pkg::MODE_RED;
                    end
                    eld_pkg::MODE_RED:
                    begin
                        held_next[2] = data;
                        mode_next    = eld_pkg::MODE_GREEN;
                    end
                    eld_pkg::MODE_GREEN:
                    begin
                        held_next[3] = data;
                        mode_next    = eld_pkg::MODE_BLUE;
                    end
                    eld_pkg::MODE_FRAME:
                    begin
                        if (frame_end)
                        begin
                            mode_next = eld_pkg::MODE_IDLE;
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 10'd1;
                        end
                    end
                    default:
                    begin
                        mode_next = eld_pkg::MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        result    = '0;
        if (fire && !is_led && !is_frame && !is_escape)
        begin
            if (is_boot)
            begin
                res_valid   = 1'b1;
                result.kind = eld_pkg::KIND_BOOT;
            end
            else if (mode_reg == eld_pkg::MODE_BLUE)
            begin
                res_valid     = in_range;
                result.kind   = eld_pkg::KIND_LED;
                result.column = held_reg[0];
                result.row    = held_reg[1];
                result.red    = held_reg[2];
                result.green  = held_reg[3];
                result.blue   = data;
            end
            else if (mode_reg == eld_pkg::MODE_FRAME)
            begin
                res_valid    = 1'b1;
                result.kind  = eld_pkg::KIND_FRAME;
                result.index = pos_reg;
                result.data  = data;
                result.last  = frame_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= eld_pkg::MODE_IDLE;
            escape_reg <= 1'b0;
            held_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            escape_reg <= escape_next;
            held_reg   <= held_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ===== rtl/eld_out_stage.sv =====
module eld_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  eld_pkg::result_t result,
    output logic             take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output eld_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    eld_pkg::result_t result_reg;

    assign take       = !valid_reg || m_tready;
    assign valid_next = take ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid   = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== rtl/escaped_led_command_deframer.sv =====
// Escaped LED command deframer.
// Slave channel s_*: one received serial byte per item in s_tdata[7:0].
// Master channel m_*: one event per item. m_tuser carries the event kind
// (LED set, frame byte, bootloader request), m_tlast flags the last byte of
// a frame, m_tdata carries the LED command or the frame byte and its index.
// Control bytes (except the bootloader byte, which gives a bootloader event)
// and incomplete or out-of-range commands give no item. A taken byte is held in
// the input register, parsed by the combinational parse logic, and its event is registered in the output register.
// Throughput: one byte per cycle unless m_tready stalls a waiting event, set
// by the combinational parse logic between the input and output registers.
// When m_tready is low and an event is waiting, the input register still takes
// one more byte if it is empty; after that s_tready drops until the event is taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to idle with no escape armed and no partial command or frame.
`include "escaped_led_command_deframer_defines.svh"

module escaped_led_command_deframer
#(
    parameter int FRAME_BYTES = eld_pkg::FRAME_BYTES_DEF,
    parameter int COLUMNS     = eld_pkg::COLUMNS_DEF,
    parameter int ROWS        = eld_pkg::ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // led_column, led_row, red_level, green_level,
                                   // blue_level, frame_index, frame_byte, zero pad
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast    // frame_last
);

    logic             take;
    logic             byte_valid;
    logic [7:0]       rx_byte;
    logic             res_valid;
    eld_pkg::result_t result;
    eld_pkg::result_t out_result;

    eld_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    eld_parser
    #(
        .FRAME_BYTES (FRAME_BYTES),
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS)
    )
    u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (byte_valid && take),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .result    (result)
    );

    eld_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .result     (result),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {6'b0, out_result.data, out_result.index, out_result.blue,
                      out_result.green, out_result.red, out_result.row,
                      out_result.column};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

    `ELD_ASSERT_IMPL(a_last_is_frame, m_tvalid && m_tlast,
                     m_tuser == eld_pkg::KIND_FRAME, "tlast on non-frame item")
    `ELD_ASSERT_IMPL(a_led_in_range, m_tvalid && m_tuser == eld_pkg::KIND_LED,
                     (9'(m_tdata[7:0]) < 9'(COLUMNS)) && (9'(m_tdata[15:8]) < 9'(ROWS)),
                     "LED item out of range")
    `ELD_ASSERT_IMPL(a_index_in_range, m_tvalid && m_tuser == eld_pkg::KIND_FRAME,
                     11'(m_tdata[49:40]) < 11'(FRAME_BYTES), "frame index past frame end")
    `ELD_ASSERT_NEXT(a_result_lands, byte_valid && take && res_valid, m_tvalid,
                     "parsed event lost")

endmodule
